// File: rtl/dcbp_pkg.sv
`default_nettype none

package dcbp_pkg;

    localparam int PATTERN_BYTES = 8;
    localparam int STORE_DEPTH   = 8;
    localparam int STORE_IDX_W   = 3;
    localparam int COUNT_W       = 4;
    localparam int PATTERN_W     = 8 * STORE_DEPTH;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = 1;
    localparam int QUEUE_CNT_W   = 2;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_LED   = 2'd1;
    localparam logic [1:0] ACT_DRAW  = 2'd2;

    localparam logic [7:0] CMD_CLEAR = 8'h01;
    localparam logic [7:0] CMD_LED   = 8'h02;
    localparam int         DRAW_FLAG_BIT = 7;

    typedef logic [1:0] action_t;

    typedef struct packed {
        action_t              action;
        logic [7:0]           data;
        logic [3:0]           column;
        logic [2:0]           row;
        logic [PATTERN_W-1:0] pattern;
    } op_t;

endpackage

`default_nettype wire

// File: rtl/dcbp_if.sv
`default_nettype none

interface dcbp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dcbp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  led_level;
    logic [3:0]  draw_column;
    logic [2:0]  draw_row;
    logic [63:0] draw_pattern;

    modport source (output valid, output action, output led_level, output draw_column,
                    output draw_row, output draw_pattern, input ready);
    modport sink   (input valid, input action, input led_level, input draw_column,
                    input draw_row, input draw_pattern, output ready);
endinterface

`default_nettype wire

// File: rtl/display_command_byte_parser.sv
// channel | dir | payload                                                  | handshake
// rx      | in  | rx_byte                                                  | valid/ready
// act     | out | action, led_level, draw_column, draw_row, draw_pattern   | valid/ready
//
// one byte per cycle is taken while the two-entry request queue has room
// act.valid rises when the op queued on the completing byte is loaded from the queue into the output register
// rx and act stall independently; the queue plus output register absorb act stalls
// rst_n clears mode, position, byte count, queue and output valid; pattern bytes are not reset
`default_nettype none

module display_command_byte_parser
    import dcbp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    dcbp_in_if.sink    rx,
    dcbp_out_if.source act
);

    logic op_valid;
    op_t  op;
    logic q_not_full;
    logic q_valid;
    op_t  q_op;
    logic q_pop;

    dcbp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .q_ready  (q_not_full),
        .op_valid (op_valid),
        .op       (op)
    );

    dcbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (op_valid),
        .push_op    (op),
        .not_full   (q_not_full),
        .head_valid (q_valid),
        .head_op    (q_op),
        .pop        (q_pop)
    );

    dcbp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_op    (q_op),
        .q_pop   (q_pop),
        .tx      (act)
    );

endmodule

`default_nettype wire

// File: rtl/dcbp_front.sv
`default_nettype none

module dcbp_front
    import dcbp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    dcbp_in_if.sink    rx,
    input  wire logic  q_ready,
    output logic       op_valid,
    output op_t        op
);

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_LED  = 2'd1;
    localparam logic [1:0] MODE_DRAW = 2'd2;

    logic [1:0]         mode_reg, mode_next;
    logic [3:0]         column_reg, column_next;
    logic [2:0]         row_reg, row_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] count_inc;
    logic [7:0]         store_reg [STORE_DEPTH];
    logic [STORE_IDX_W-1:0] idx;
    logic [PATTERN_W-1:0]   pattern;
    logic               fire;

    assign rx.ready  = q_ready;
    assign fire      = rx.valid && q_ready;
    assign idx       = count_reg[STORE_IDX_W-1:0];
    assign count_inc = count_reg + COUNT_W'(1);

    // current byte completes the pattern in the same cycle
    always_comb
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            if (i < PATTERN_BYTES)
            begin
                pattern[8*i +: 8] = (idx == STORE_IDX_W'(i)) ? rx.rx_byte : store_reg[i];
            end
            else
            begin
                pattern[8*i +: 8] = 8'h00;
            end
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        column_next = column_reg;
        row_next    = row_reg;
        count_next  = count_reg;
        op_valid    = 1'b0;
        op          = '0;
        op.data     = rx.rx_byte;
        op.column   = column_reg;
        op.row      = row_reg;
        if (fire)
        begin
            unique case (mode_reg)
                MODE_LED:
                begin
                    mode_next = MODE_IDLE;
                    op_valid  = 1'b1;
                    op.action = ACT_LED;
                end
                MODE_DRAW:
                begin
                    count_next = count_inc;
                    if (count_inc == COUNT_W'(PATTERN_BYTES))
                    begin
                        mode_next  = MODE_IDLE;
                        op_valid   = 1'b1;
                        op.action  = ACT_DRAW;
                        op.pattern = pattern;
                    end
                end
                default:
                begin
                    priority if (rx.rx_byte == CMD_CLEAR)
                    begin
                        mode_next = MODE_IDLE;
                        op_valid  = 1'b1;
                        op.action = ACT_CLEAR;
                    end
                    else if (rx.rx_byte == CMD_LED)
                    begin
                        mode_next = MODE_LED;
                    end
                    else if (rx.rx_byte[DRAW_FLAG_BIT])
                    begin
                        mode_next   = MODE_DRAW;
                        column_next = rx.rx_byte[3:0];
                        row_next    = rx.rx_byte[6:4];
                        count_next  = '0;
                    end
                    else
                    begin
                        mode_next   = MODE_IDLE;
                        column_next = '0;
                        row_next    = '0;
                        count_next  = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            column_reg <= '0;
            row_reg    <= '0;
            count_reg  <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            column_reg <= column_next;
            row_reg    <= row_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && mode_reg == MODE_DRAW)
        begin
            store_reg[idx] <= rx.rx_byte;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dcbp_queue.sv
`default_nettype none

module dcbp_queue
    import dcbp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  op_t       push_op,
    output logic      not_full,
    output logic      head_valid,
    output op_t       head_op,
    input  wire logic pop
);

    op_t                    entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push, do_pop;

    assign not_full   = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = entry_reg[rd_ptr_reg];
    assign do_push    = push && not_full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + QUEUE_CNT_W'(1);
            2'b01:   count_next = count_reg - QUEUE_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dcbp_back.sv
`default_nettype none

module dcbp_back
    import dcbp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_valid,
    input  op_t        q_op,
    output logic       q_pop,
    dcbp_out_if.source tx
);

    logic                 valid_reg;
    action_t              action_reg;
    logic [7:0]           led_reg;
    logic [3:0]           column_reg;
    logic [2:0]           row_reg;
    logic [PATTERN_W-1:0] pattern_reg;
    logic                 load;
    logic                 is_led, is_draw;

    assign load    = !valid_reg || tx.ready;
    assign q_pop   = q_valid && load;
    assign is_led  = (q_op.action == ACT_LED);
    assign is_draw = (q_op.action == ACT_DRAW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= q_valid;
        end
    end

    // unused fields of each action go out as zero
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            action_reg  <= q_op.action;
            led_reg     <= is_led  ? ~q_op.data   : 8'h00;
            column_reg  <= is_draw ? q_op.column  : 4'h0;
            row_reg     <= is_draw ? q_op.row     : 3'h0;
            pattern_reg <= is_draw ? q_op.pattern : '0;
        end
    end

    assign tx.valid        = valid_reg;
    assign tx.action       = action_reg;
    assign tx.led_level    = led_reg;
    assign tx.draw_column  = column_reg;
    assign tx.draw_row     = row_reg;
    assign tx.draw_pattern = pattern_reg;

endmodule

`default_nettype wire

// File: rtl/dcbp_checker.sv
`default_nettype none

module dcbp_checker
    import dcbp_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  action,
    input wire logic [7:0]  led_level,
    input wire logic [3:0]  draw_column,
    input wire logic [2:0]  draw_row,
    input wire logic [63:0] draw_pattern
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(action) && $stable(draw_pattern))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> action == ACT_CLEAR || action == ACT_LED || action == ACT_DRAW)
        else $error("bad action code");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action != ACT_DRAW |-> draw_pattern == '0 && draw_column == '0
            && draw_row == '0)
        else $error("draw fields set on non-draw result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action != ACT_LED |-> led_level == '0)
        else $error("led level set on non-led result");

endmodule

bind display_command_byte_parser dcbp_checker u_dcbp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (act.valid),
    .out_ready    (act.ready),
    .action       (act.action),
    .led_level    (act.led_level),
    .draw_column  (act.draw_column),
    .draw_row     (act.draw_row),
    .draw_pattern (act.draw_pattern)
);

`default_nettype wire
